// ----- rtl/xics_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xics_pkg: shared types, constants and helpers
// Code unit width, markup characters, the op record handed from the
// front end to the back end, and XML character class functions.
// ----------------------------------------------------------------------------
package xics_pkg;

  localparam int UNIT_W            = 16;
  localparam int QUEUE_DEPTH_DEF   = 2;
  localparam logic [UNIT_W-1:0] REPL_RESET = 16'h003F;

  // Markup characters
  localparam logic [UNIT_W-1:0] CH_LT    = 16'h003C;
  localparam logic [UNIT_W-1:0] CH_GT    = 16'h003E;
  localparam logic [UNIT_W-1:0] CH_APOS  = 16'h0027;
  localparam logic [UNIT_W-1:0] CH_QUOT  = 16'h0022;

  // Prefix beat kind ahead of the main beat
  typedef enum logic [1:0] {
    PRE_NONE,   // no prefix beat
    PRE_REPL,   // broken surrogate pair: replacement beat
    PRE_HELD    // completed pair: held high surrogate unchanged
  } pre_kind_t;

  typedef struct packed {
    pre_kind_t         pre;
    logic [UNIT_W-1:0] pre_unit;
    logic              main_valid;
    logic [UNIT_W-1:0] main_unit;
    logic              main_repl;
    logic              main_end;
  } xics_op_t;

  function automatic logic unit_valid(input logic [UNIT_W-1:0] u);
    return (u == 16'h0009) || (u == 16'h000A) || (u == 16'h000D) ||
           ((u >= 16'h0020) && (u <= 16'hD7FF)) ||
           ((u >= 16'hE000) && (u <= 16'hFFFD));
  endfunction

  function automatic logic unit_high(input logic [UNIT_W-1:0] u);
    return (u >= 16'hD800) && (u <= 16'hDBFF);
  endfunction

  function automatic logic unit_low(input logic [UNIT_W-1:0] u);
    return (u >= 16'hDC00) && (u <= 16'hDFFF);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/xics_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xics_front: markup tracker and classifier
// Accepts code units, follows tag/quote state, holds high surrogates and
// turns each unit into an op record for the back end.
// ----------------------------------------------------------------------------
module xics_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [xics_pkg::UNIT_W-1:0] in_code_unit,
  input  wire logic                       in_is_last,
  input  wire logic                       q_full,
  output logic                            q_push,
  output xics_pkg::xics_op_t              q_op
);
  import xics_pkg::*;

  logic              tag_r, tag_nxt;
  logic              quote_r, quote_nxt;
  logic              dbl_r, dbl_nxt;
  logic              held_r, held_nxt;
  logic [UNIT_W-1:0] held_unit_r, held_unit_nxt;
  logic              accept;
  logic              is_dbl;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_dbl   = (in_code_unit == CH_QUOT);

  always_comb begin
    tag_nxt       = tag_r;
    quote_nxt     = quote_r;
    dbl_nxt       = dbl_r;
    held_nxt      = held_r;
    held_unit_nxt = held_unit_r;
    q_op          = '0;
    q_push        = 1'b0;
    if (accept) begin
      if (held_r && unit_low(in_code_unit)) begin
        // pair completes; tracking untouched
        held_nxt        = 1'b0;
        q_op.pre        = PRE_HELD;
        q_op.pre_unit   = held_unit_r;
        q_op.main_valid = 1'b1;
        q_op.main_unit  = in_code_unit;
        q_op.main_end   = in_is_last;
      end else begin
        held_nxt = 1'b0;
        if (held_r) begin
          q_op.pre = PRE_REPL;
        end
        if (in_code_unit == CH_LT) begin
          tag_nxt = 1'b1;
        end else if (in_code_unit == CH_GT) begin
          if (!quote_r) begin
            tag_nxt = 1'b0;
          end
        end else if ((in_code_unit == CH_APOS) || is_dbl) begin
          if (tag_r) begin
            if (!quote_r) begin
              quote_nxt = 1'b1;
              dbl_nxt   = is_dbl;
            end else if (is_dbl == dbl_r) begin
              quote_nxt = 1'b0;
            end
          end
        end
        q_op.main_unit = in_code_unit;
        q_op.main_end  = in_is_last;
        if ((tag_nxt && !quote_nxt) || unit_valid(in_code_unit)) begin
          q_op.main_valid = 1'b1;
        end else if (unit_high(in_code_unit) && !in_is_last) begin
          held_nxt      = 1'b1;
          held_unit_nxt = in_code_unit;
        end else begin
          q_op.main_valid = 1'b1;
          q_op.main_repl  = 1'b1;
        end
      end
      q_push = (q_op.pre != PRE_NONE) || q_op.main_valid;
      if (in_is_last) begin
        tag_nxt   = 1'b0;
        quote_nxt = 1'b0;
        dbl_nxt   = 1'b0;
        held_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r   <= 1'b0;
      quote_r <= 1'b0;
      dbl_r   <= 1'b0;
      held_r  <= 1'b0;
    end else begin
      tag_r   <= tag_nxt;
      quote_r <= quote_nxt;
      dbl_r   <= dbl_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_unit_r <= held_unit_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/xics_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xics_fifo: op queue between front and back end
// Small register queue of op records, full/valid flags from a fill count.
// ----------------------------------------------------------------------------
module xics_fifo #(
  parameter int DEPTH = xics_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire xics_pkg::xics_op_t wr_op,
  output logic                    full,
  input  wire logic               pop,
  output logic                    rd_valid,
  output xics_pkg::xics_op_t      rd_op
);
  import xics_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  xics_op_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_op    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_op;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("op queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rd_valid)
    else $error("op queue underflow");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("op queue count out of range");

endmodule
`default_nettype wire

// ----- rtl/xics_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xics_back: result emitter
// Expands each queued op into one or two output beats, applies the
// replacement unit and holds them in the output register.
// ----------------------------------------------------------------------------
module xics_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire xics_pkg::xics_op_t          q_op,
  output logic                             q_pop,
  input  wire logic [xics_pkg::UNIT_W-1:0] repl_unit,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [xics_pkg::UNIT_W-1:0]      out_unit,
  output logic                             out_was_replaced,
  output logic                             out_end_of_text
);
  import xics_pkg::*;

  logic              phase_r, phase_nxt;   // 1: prefix beat sent, main next
  logic              valid_r, valid_nxt;
  logic [UNIT_W-1:0] unit_r, unit_nxt;
  logic              repl_r, repl_nxt;
  logic              end_r, end_nxt;
  logic              load;
  logic              first_pre;
  logic              two_beats;

  assign load      = q_valid && (!valid_r || !out_stall);
  assign first_pre = !phase_r && (q_op.pre != PRE_NONE);
  assign two_beats = first_pre && q_op.main_valid;
  assign q_pop     = load && !two_beats;

  always_comb begin
    unit_nxt  = unit_r;
    repl_nxt  = repl_r;
    end_nxt   = end_r;
    phase_nxt = phase_r;
    valid_nxt = valid_r && out_stall;
    if (load) begin
      valid_nxt = 1'b1;
      phase_nxt = two_beats;
      if (first_pre) begin
        end_nxt = 1'b0;
        case (q_op.pre)
          PRE_REPL: begin
            unit_nxt = repl_unit;
            repl_nxt = 1'b1;
          end
          PRE_HELD: begin
            unit_nxt = q_op.pre_unit;
            repl_nxt = 1'b0;
          end
          default: begin
            unit_nxt = q_op.main_unit;
            repl_nxt = 1'b0;
          end
        endcase
      end else begin
        unit_nxt = q_op.main_repl ? repl_unit : q_op.main_unit;
        repl_nxt = q_op.main_repl;
        end_nxt  = q_op.main_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r <= unit_nxt;
    repl_r <= repl_nxt;
    end_r  <= end_nxt;
  end

  assign out_valid        = valid_r;
  assign out_unit         = unit_r;
  assign out_was_replaced = repl_r;
  assign out_end_of_text  = end_r;

  a_phase_has_op: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> q_valid)
    else $error("second beat pending without a queued op");

  a_prefix_not_end: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && phase_r |-> !end_r)
    else $error("prefix beat marked end of text");

  a_phase_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(phase_r) |-> valid_r)
    else $error("prefix beat not in output register");

endmodule
`default_nettype wire

// ----- rtl/xml_invalid_char_scrubber.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xml_invalid_char_scrubber: XML invalid character scrubber, UTF-16
// Replaces non-XML chars in text and attribute values with a configured unit.
// ----------------------------------------------------------------------------
// The block scrubs one UTF-16 code unit per cycle unless stalled. A front
// end follows the markup ('<' opens a tag, '>' outside quotes closes it,
// ' and " open and close attribute values) and classifies each unit; a
// back end emits the beats. Between them sits an op queue of QUEUE_DEPTH
// entries, so input and output stall independently. Throughput is one
// input and one output beat per cycle, each while its stall is low.
// A high surrogate in text or an attribute value, unless it is the last
// unit, produces no beat when taken in and is held until the next unit:
// a low surrogate then sends both units unchanged (two output beats),
// anything else first sends a replacement beat for the held unit. An
// accepted unit passes through the op queue into the output register. All
// tracking state clears after a beat marked in_is_last. The replacement
// unit (reset 0x003F) is written through the cfg port, always ready;
// write it only while no text is in flight, unchecked by the block.
// ----------------------------------------------------------------------------
module xml_invalid_char_scrubber #(
  parameter int QUEUE_DEPTH = xics_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [xics_pkg::UNIT_W-1:0] in_code_unit,
  input  wire logic                        in_is_last,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [xics_pkg::UNIT_W-1:0]      out_unit,
  output logic                             out_was_replaced,
  output logic                             out_end_of_text,
  // configuration
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [xics_pkg::UNIT_W-1:0] cfg_replacement_unit
);
  import xics_pkg::*;

  logic [UNIT_W-1:0] repl_r, repl_nxt;
  logic              q_push, q_full, q_pop, q_valid;
  xics_op_t          push_op, head_op;

  // replacement unit register
  assign cfg_ready = 1'b1;
  assign repl_nxt  = (cfg_valid && cfg_ready) ? cfg_replacement_unit : repl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= REPL_RESET;
    end else begin
      repl_r <= repl_nxt;
    end
  end

  // front end: markup tracking, surrogate hold, classification
  xics_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_code_unit (in_code_unit),
    .in_is_last   (in_is_last),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_op         (push_op)
  );

  // op queue decoupling the two ends
  xics_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_op    (push_op),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_op    (head_op)
  );

  // back end: one or two beats per op into the output register
  xics_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_op             (head_op),
    .q_pop            (q_pop),
    .repl_unit        (repl_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_unit         (out_unit),
    .out_was_replaced (out_was_replaced),
    .out_end_of_text  (out_end_of_text)
  );

endmodule
`default_nettype wire
